[design/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AST_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define AST_IMPLIES(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

`define AST_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`else

`define AST_HOLDS(lbl, clk, rstn, prop, msg)

`define AST_IMPLIES(lbl, clk, rstn, pre, post, msg)

`define AST_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

[design/itp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int SYM_W       = 8;

  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAREN    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    K_END,
    K_ALNUM,
    K_OPEN,
    K_CLOSE,
    K_OPER
  } kind_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [SYM_W-1:0] data;
  } stk_cmd_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             term;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    stk_cmd_t cmd;
    logic     has_res;
    result_t  res;
    logic     done;
  } dec_t;

  function automatic logic [1:0] rank_of(input logic [SYM_W-1:0] c);
    logic [1:0] r;
    case (c) inside
      CH_PLUS, CH_MINUS: r = 2'd1;
      CH_STAR, CH_SLASH: r = 2'd2;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic kind_t classify(input logic [SYM_W-1:0] c, input logic end_mark);
    kind_t k;
    if (end_mark) begin
      k = K_END;
    end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A)) begin
      k = K_ALNUM;
    end else if (c == CH_OPEN) begin
      k = K_OPEN;
    end else if (c == CH_CLOSE) begin
      k = K_CLOSE;
    end else begin
      k = K_OPER;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[design/itp_stack.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module itp_stack #(
  parameter int DEPTH = itp_pkg::STACK_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire itp_pkg::stk_cmd_t       cmd_i,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [itp_pkg::SYM_W-1:0]    top_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [itp_pkg::SYM_W-1:0] mem [DEPTH];
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [IW-1:0]             rd_addr;
  logic [itp_pkg::SYM_W-1:0] top_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd_i.clear) begin
      count_nxt = '0;
    end else if (cmd_i.push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd_i.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // index of the entry that becomes the top after this cycle's operation
  assign rd_addr = IW'(count_nxt - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.push) begin
      mem[IW'(count_r)] <= cmd_i.data;
    end
    // a push bypasses the array so the top register takes the pushed symbol directly
    if (cmd_i.push) begin
      top_r <= cmd_i.data;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CW'(DEPTH));
  assign top_o   = top_r;

  `AST_HOLDS(a_no_push_full, clk, rst_n, !(cmd_i.push && full_o), "push onto full stack")
  `AST_HOLDS(a_no_pop_empty, clk, rst_n, !(cmd_i.pop && empty_o), "pop from empty stack")
  `AST_HOLDS(a_count_range, clk, rst_n, count_r <= CW'(DEPTH), "stack count beyond depth")

endmodule

`default_nettype wire

[design/itp_decide.sv]
`timescale 1ns / 1ps
`default_nettype none

module itp_decide (
  input  wire itp_pkg::kind_t          kind_i,
  input  wire logic [itp_pkg::SYM_W-1:0] sym_i,
  input  wire logic [1:0]              rank_i,
  input  wire logic                    empty_i,
  input  wire logic                    full_i,
  input  wire logic [itp_pkg::SYM_W-1:0] top_i,
  output itp_pkg::dec_t                dec_o
);

  logic top_open;
  logic top_ge;

  assign top_open = (top_i == itp_pkg::CH_OPEN);
  // the one rank comparator, used on every operator step
  assign top_ge   = (itp_pkg::rank_of(top_i) >= rank_i);

  always_comb begin
    dec_o            = '0;
    dec_o.cmd.data   = sym_i;
    dec_o.res.status = itp_pkg::ST_OK;
    unique case (kind_i)
      itp_pkg::K_ALNUM: begin
        dec_o.has_res = 1'b1;
        dec_o.res.sym = sym_i;
        dec_o.done    = 1'b1;
      end
      itp_pkg::K_OPEN: begin
        dec_o.done = 1'b1;
        if (full_i) begin
          dec_o.has_res    = 1'b1;
          dec_o.res.status = itp_pkg::ST_OVERFLOW;
        end else begin
          dec_o.cmd.push = 1'b1;
        end
      end
      itp_pkg::K_CLOSE: begin
        if (empty_i) begin
          dec_o.has_res    = 1'b1;
          dec_o.res.status = itp_pkg::ST_PAREN;
          dec_o.done       = 1'b1;
        end else if (top_open) begin
          dec_o.cmd.pop = 1'b1;
          dec_o.done    = 1'b1;
        end else begin
          dec_o.cmd.pop = 1'b1;
          dec_o.has_res = 1'b1;
          dec_o.res.sym = top_i;
        end
      end
      itp_pkg::K_OPER: begin
        if (!empty_i && top_ge) begin
          dec_o.cmd.pop = 1'b1;
          dec_o.has_res = 1'b1;
          dec_o.res.sym = top_i;
        end else if (full_i) begin
          dec_o.has_res    = 1'b1;
          dec_o.res.status = itp_pkg::ST_OVERFLOW;
          dec_o.done       = 1'b1;
        end else begin
          dec_o.cmd.push = 1'b1;
          dec_o.done     = 1'b1;
        end
      end
      itp_pkg::K_END: begin
        if (empty_i) begin
          dec_o.has_res  = 1'b1;
          dec_o.res.term = 1'b1;
          dec_o.done     = 1'b1;
        end else if (top_open) begin
          dec_o.cmd.clear  = 1'b1;
          dec_o.has_res    = 1'b1;
          dec_o.res.status = itp_pkg::ST_PAREN;
          dec_o.done       = 1'b1;
        end else begin
          dec_o.cmd.pop = 1'b1;
          dec_o.has_res = 1'b1;
          dec_o.res.sym = top_i;
        end
      end
      default: begin
        dec_o.done = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/infix_to_postfix_stream_top.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Infix to postfix converter, one ASCII character per input transaction, using an
// operator stack held in a small on-chip array (no clearing pass after reset; the
// stack starts empty). Letters and digits come straight back out; operators and
// parentheses are reordered by precedence; an end transaction flushes the stack and
// gives a terminator, or a status 1 result if a '(' is left open. A result carries
// tlast on the final output of its input transaction. Timing: one input is worked on
// at a time and in_tready is low until its last result has been taken. A single
// decision unit makes one stack step per cycle while evaluating, stalling when a
// held result must go out first, and every result passes through one output
// register. An input that gives no result goes straight back to idle; otherwise a
// result is held until the next result or the final stack step (which may give none,
// as a matched ')' or a push after pops), and is then sent. Output stalls hold it.
module infix_to_postfix_stream_top #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic       in_tuser,   // [0] end_of_expr
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_symbol
  output logic [2:0]      out_tuser,  // [0] is_terminator, [2:1] status
  output logic            out_tlast
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   pend_v_r, pend_v_nxt;
  logic   pend_last_r, pend_last_nxt;

  itp_pkg::result_t          pend_res_r, pend_res_nxt;
  itp_pkg::kind_t            kind_r;
  logic [itp_pkg::SYM_W-1:0] sym_r;
  logic [1:0]                rank_r;

  itp_pkg::dec_t             dec;
  itp_pkg::stk_cmd_t         stk_cmd;
  logic                      stk_empty;
  logic                      stk_full;
  logic [itp_pkg::SYM_W-1:0] stk_top;
  logic                      in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  itp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_i   (stk_cmd),
    .empty_o (stk_empty),
    .full_o  (stk_full),
    .top_o   (stk_top)
  );

  itp_decide u_decide (
    .kind_i  (kind_r),
    .sym_i   (sym_r),
    .rank_i  (rank_r),
    .empty_i (stk_empty),
    .full_i  (stk_full),
    .top_i   (stk_top),
    .dec_o   (dec)
  );

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    pend_v_nxt    = pend_v_r;
    pend_last_nxt = pend_last_r;
    pend_res_nxt  = pend_res_r;
    stk_cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (dec.has_res && pend_v_r) begin
          // another result follows, so the held one is not the last
          pend_last_nxt = 1'b0;
          ret_nxt       = S_EVAL;
          state_nxt     = S_SEND;
        end else begin
          stk_cmd = dec.cmd;
          if (dec.has_res) begin
            pend_res_nxt = dec.res;
            pend_v_nxt   = 1'b1;
          end
          if (dec.done) begin
            if (dec.has_res || pend_v_r) begin
              pend_last_nxt = 1'b1;
              ret_nxt       = S_IDLE;
              state_nxt     = S_SEND;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_SEND: begin
        if (out_tready) begin
          pend_v_nxt = 1'b0;
          state_nxt  = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_res_r  <= pend_res_nxt;
    pend_last_r <= pend_last_nxt;
    if (in_fire) begin
      sym_r  <= in_tdata;
      kind_r <= itp_pkg::classify(in_tdata, in_tuser);
      rank_r <= itp_pkg::rank_of(in_tdata);
    end
  end

  assign out_tvalid = (state_r == S_SEND);
  assign out_tdata  = pend_res_r.sym;
  assign out_tuser  = {pend_res_r.status, pend_res_r.term};
  assign out_tlast  = pend_last_r;

  `AST_IMPLIES(a_err_last, clk, rst_n, out_tvalid && (pend_res_r.status != itp_pkg::ST_OK), out_tlast, "error result not final")
  `AST_IMPLIES(a_term_last, clk, rst_n, out_tvalid && pend_res_r.term, out_tlast, "terminator not final")
  `AST_NEXT(a_accept_eval, clk, rst_n, in_fire, state_r == S_EVAL, "accepted item not evaluated")
  `AST_HOLDS(a_send_pending, clk, rst_n, !out_tvalid || pend_v_r, "output without held result")

endmodule

`default_nettype wire
